### rtl/absd_pkg.sv
// Package for the ASCII 2x2 block smoothing and dither pipeline.
// Holds payload types, the palette tables and the dither matrix.
// No dependencies.
package absd_pkg;

	localparam int unsigned CellCount = 4;

	typedef logic [7:0] char_t;
	typedef logic [7:0] level_t;
	typedef logic [3:0] pal_idx_t;

	localparam logic [7:0] THRESH_RESET = 8'd128;
	localparam pal_idx_t   PAL_LAST     = 4'd9;

	typedef struct packed {
		char_t char_top_left;
		char_t char_top_right;
		char_t char_bottom_left;
		char_t char_bottom_right;
		logic  right_present;
		logic  bottom_present;
	} blk_in_t;

	typedef struct packed {
		char_t out_top_left;
		char_t out_top_right;
		char_t out_bottom_left;
		char_t out_bottom_right;
	} blk_out_t;

	typedef struct packed {
		logic s3;
		logic s4;
	} cell_adv_t;

	// brightness i*255/9 of palette symbol i, zero for anything else
	function automatic level_t char_level(input char_t c);
		level_t l;
		case (c)
			8'h20: l = 8'd0;
			8'h2E: l = 8'd28;
			8'h3A: l = 8'd56;
			8'h2D: l = 8'd85;
			8'h3D: l = 8'd113;
			8'h2B: l = 8'd141;
			8'h2A: l = 8'd170;
			8'h23: l = 8'd198;
			8'h25: l = 8'd226;
			8'h40: l = 8'd255;
			default: l = 8'd0;
		endcase
		return l;
	endfunction

	function automatic char_t palette_char(input pal_idx_t idx);
		char_t c;
		case (idx)
			4'd0: c = 8'h20;
			4'd1: c = 8'h2E;
			4'd2: c = 8'h3A;
			4'd3: c = 8'h2D;
			4'd4: c = 8'h3D;
			4'd5: c = 8'h2B;
			4'd6: c = 8'h2A;
			4'd7: c = 8'h23;
			4'd8: c = 8'h25;
			default: c = 8'h40;
		endcase
		return c;
	endfunction

	// 2x2 ordered dither matrix {{0,2},{3,1}}
	function automatic logic [1:0] bayer(input logic row, input logic col);
		logic [1:0] b;
		case ({row, col})
			2'b00: b = 2'd0;
			2'b01: b = 2'd2;
			2'b10: b = 2'd3;
			default: b = 2'd1;
		endcase
		return b;
	endfunction

endpackage

### rtl/absd_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
// Payload type is set by the instantiating module.
interface absd_stream_if #(
	parameter type PAYLOAD_T = logic
);
	logic     valid;
	logic     ready;
	PAYLOAD_T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/ascii_block_smoothing_dither.sv
// ASCII 2x2 block smoothing with ordered dither, top level.
// Depends on absd_pkg, absd_stream_if and absd_cell.
//
// Usage:
//   blocks   - sink channel, one 2x2 character block per transaction, with
//              flags for a present right column and bottom row.
//   smoothed - source channel, one result block per input transaction.
//   threshold_we / threshold_wdata - write the difference threshold; write
//              only while no transaction is in flight.
// Timing: four register stages (palette lookup, block mean, threshold test
// and dither value, palette index), passed through in that order; throughput
// is one block per cycle while smoothed.ready stays high.
// Reset: the pipeline empties and the threshold returns to 128.
// Stall: when smoothed.ready is low the last stage holds its result; earlier
// stages keep filling bubbles, and blocks.ready drops once every stage is
// occupied. Nothing is lost or repeated.
module ascii_block_smoothing_dither (
	input  logic                  clk,
	input  logic                  arst_n,
	absd_stream_if.sink           blocks,
	absd_stream_if.source         smoothed,
	input  logic                  threshold_we,
	input  logic [7:0]            threshold_wdata
);
	import absd_pkg::*;

	logic [7:0] threshold_q;
	logic       v_s1, v_s2, v_s3, v_s4;
	logic       adv1, adv2, adv3, adv4;
	cell_adv_t  cell_adv;

	char_t  in_chars [CellCount];
	logic   in_present [CellCount];

	char_t  char_s1 [CellCount];
	logic   present_s1 [CellCount];
	level_t level_s1 [CellCount];
	char_t  char_s2 [CellCount];
	logic   present_s2 [CellCount];
	level_t level_s2 [CellCount];
	level_t mean_s2;
	logic [9:0] sum;
	char_t  result_s4 [CellCount];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESH_RESET;
		end else if (threshold_we) begin
			threshold_q <= threshold_wdata;
		end
	end

	always_comb begin
		adv4 = !v_s4 || smoothed.ready;
		adv3 = !v_s3 || adv4;
		adv2 = !v_s2 || adv3;
		adv1 = !v_s1 || adv2;
		cell_adv.s3 = adv3;
		cell_adv.s4 = adv4;
	end

	assign blocks.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= blocks.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	always_comb begin
		in_chars[0]   = blocks.data.char_top_left;
		in_chars[1]   = blocks.data.char_top_right;
		in_chars[2]   = blocks.data.char_bottom_left;
		in_chars[3]   = blocks.data.char_bottom_right;
		in_present[0] = 1'b1;
		in_present[1] = blocks.data.right_present;
		in_present[2] = blocks.data.bottom_present;
		in_present[3] = blocks.data.right_present && blocks.data.bottom_present;
		sum = {2'b0, level_s1[0]} + {2'b0, level_s1[1]}
		    + {2'b0, level_s1[2]} + {2'b0, level_s1[3]};
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int k = 0; k < CellCount; k++) begin
				char_s1[k]    <= in_chars[k];
				present_s1[k] <= in_present[k];
				level_s1[k]   <= in_present[k] ? char_level(in_chars[k]) : '0;
			end
		end
		if (adv2) begin
			for (int k = 0; k < CellCount; k++) begin
				char_s2[k]    <= char_s1[k];
				present_s2[k] <= present_s1[k];
				level_s2[k]   <= level_s1[k];
			end
			mean_s2 <= sum[9:2];
		end
	end

	for (genvar k = 0; k < CellCount; k++) begin : g_cell
		absd_cell u_cell (
			.clk           (clk),
			.adv           (cell_adv),
			.dither_weight (bayer(k[1], k[0])),
			.threshold     (threshold_q),
			.present_s2    (present_s2[k]),
			.char_s2       (char_s2[k]),
			.level_s2      (level_s2[k]),
			.mean_s2       (mean_s2),
			.result_s4     (result_s4[k])
		);
	end

	assign smoothed.valid                 = v_s4;
	assign smoothed.data.out_top_left     = result_s4[0];
	assign smoothed.data.out_top_right    = result_s4[1];
	assign smoothed.data.out_bottom_left  = result_s4[2];
	assign smoothed.data.out_bottom_right = result_s4[3];

endmodule

### rtl/absd_cell.sv
// Per-cell back end of the smoothing pipeline: threshold test and dither (stages 3, 4).
// Depends on absd_pkg.
module absd_cell (
	input  logic                 clk,
	input  absd_pkg::cell_adv_t  adv,
	input  logic [1:0]           dither_weight,
	input  logic [7:0]           threshold,
	input  logic                 present_s2,
	input  absd_pkg::char_t      char_s2,
	input  absd_pkg::level_t     level_s2,
	input  absd_pkg::level_t     mean_s2,
	output absd_pkg::char_t      result_s4
);
	import absd_pkg::*;

	level_t      diff;
	logic [8:0]  mid_sum;
	logic [8:0]  dval;
	logic        rewrite_s3;
	logic [8:0]  dval_s3;
	char_t       char_s3;
	logic [12:0] scaled;
	logic [4:0]  idx_raw;
	pal_idx_t    idx;

	always_comb begin
		diff    = (level_s2 > mean_s2) ? (level_s2 - mean_s2) : (mean_s2 - level_s2);
		mid_sum = {1'b0, level_s2} + {1'b0, mean_s2};
		dval    = {1'b0, mid_sum[8:1]} + {1'b0, dither_weight, 6'b0};
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			rewrite_s3 <= present_s2 && (diff > threshold);
			dval_s3    <= dval;
			char_s3    <= char_s2;
		end
	end

	always_comb begin
		scaled  = {1'b0, dval_s3, 3'b0} + {3'b0, dval_s3, 1'b0};
		idx_raw = scaled[12:8];
		idx     = (idx_raw > {1'b0, PAL_LAST}) ? PAL_LAST : idx_raw[3:0];
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			result_s4 <= rewrite_s3 ? palette_char(idx) : char_s3;
		end
	end

endmodule

### tb/ascii_block_smoothing_dither_tb.sv
// Testbench for ascii_block_smoothing_dither: random and directed 2x2 character blocks,
// with results checked against a behavioural prediction of the smoothing and dither.
// Depends on absd_pkg, absd_stream_if and the block itself.
module ascii_block_smoothing_dither_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import absd_pkg::*;

	localparam string GLYPH_SET = " .:-=+*#%@";
	localparam int unsigned LONG_HOLD = 200;

	logic clk;
	logic arst_n;

	logic       in_valid = 1'b0;
	blk_in_t    in_data = '0;
	logic       out_ready = 1'b0;
	logic       thr_we = 1'b0;
	logic [7:0] thr_wdata = 8'd0;

	logic [7:0] threshold_now = THRESH_RESET;
	bit src_idle_en = 1'b1;
	bit snk_idle_en = 1'b1;
	logic hold_go = 1'b0;
	int unsigned hold_left = 0;
	int unsigned src_gap = 0;
	int unsigned snk_gap = 0;
	int unsigned mismatch_count = 0;

	blk_in_t  pending_blocks[$];
	blk_out_t expected_smoothed[$];

	absd_stream_if #(.PAYLOAD_T(blk_in_t))  blocks_if ();
	absd_stream_if #(.PAYLOAD_T(blk_out_t)) smoothed_if ();

	assign blocks_if.valid   = in_valid;
	assign blocks_if.data    = in_data;
	assign smoothed_if.ready = out_ready;

	ascii_block_smoothing_dither dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.blocks          (blocks_if),
		.smoothed        (smoothed_if),
		.threshold_we    (thr_we),
		.threshold_wdata (thr_wdata)
	);

	function automatic int unsigned glyph_brightness(input char_t c);
		for (int i = 0; i < 10; i++) begin
			if (GLYPH_SET[i] == c)
				return (i * 255) / 9;
		end
		return 0;
	endfunction

	function automatic blk_out_t smooth_block(input blk_in_t b, input logic [7:0] thr);
		char_t       ch[4];
		char_t       res[4];
		bit          pres[4];
		int unsigned lvl[4];
		int unsigned weight[4];
		int unsigned sum;
		int unsigned mean;
		int unsigned diff;
		int unsigned v;
		int unsigned idx;
		blk_out_t    r;
		ch = '{b.char_top_left, b.char_top_right, b.char_bottom_left, b.char_bottom_right};
		pres = '{1'b1, b.right_present, b.bottom_present, b.right_present && b.bottom_present};
		weight = '{0, 2, 3, 1};
		sum = 0;
		for (int k = 0; k < 4; k++) begin
			lvl[k] = pres[k] ? glyph_brightness(ch[k]) : 0;
			sum += lvl[k];
		end
		mean = sum / 4;
		for (int k = 0; k < 4; k++) begin
			res[k] = ch[k];
			if (pres[k]) begin
				diff = (lvl[k] > mean) ? lvl[k] - mean : mean - lvl[k];
				if (diff > thr) begin
					v = (lvl[k] + mean) / 2 + 64 * weight[k];
					idx = (v * 10) / 256;
					if (idx > 9)
						idx = 9;
					res[k] = GLYPH_SET[idx];
				end
			end
		end
		r.out_top_left     = res[0];
		r.out_top_right    = res[1];
		r.out_bottom_left  = res[2];
		r.out_bottom_right = res[3];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input char_t got, input char_t want);
		$display("%0t ns: mismatch on %s: got %02h, expected %02h", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic char_t random_char();
		if ($urandom_range(0, 9) < 8)
			return GLYPH_SET[$urandom_range(0, 9)];
		return char_t'($urandom_range(0, 255));
	endfunction

	function automatic blk_in_t random_block();
		blk_in_t b;
		b.char_top_left     = random_char();
		b.char_top_right    = random_char();
		b.char_bottom_left  = random_char();
		b.char_bottom_right = random_char();
		b.right_present     = $urandom_range(0, 3) != 0;
		b.bottom_present    = $urandom_range(0, 3) != 0;
		return b;
	endfunction

	task automatic push_block(input char_t tl, input char_t tr, input char_t bl, input char_t br,
			input logic rp, input logic bp);
		blk_in_t b;
		b.char_top_left     = tl;
		b.char_top_right    = tr;
		b.char_bottom_left  = bl;
		b.char_bottom_right = br;
		b.right_present     = rp;
		b.bottom_present    = bp;
		pending_blocks.push_back(b);
	endtask

	// sample away from the rising edge so the driver and monitor have settled
	task automatic drain();
		while (pending_blocks.size() != 0 || in_valid || expected_smoothed.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_threshold(input logic [7:0] v);
		@(posedge clk);
		thr_we <= 1'b1;
		thr_wdata <= v;
		threshold_now = v;
		@(posedge clk);
		thr_we <= 1'b0;
	endtask

	task automatic run_random(input int unsigned n);
		repeat (n)
			pending_blocks.push_back(random_block());
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		fork
			forever #1 clk = ~clk;
			begin
				repeat (10) @(posedge clk);
				arst_n <= 1'b1;
			end
		join_none
	end

	initial begin
		#400us;
		$display("*** FAILED ***");
		$finish;
	end

	// driver: hold the payload until the transaction completes
	always @(posedge clk) begin
		if (arst_n && (!in_valid || blocks_if.ready)) begin
			if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				in_valid <= 1'b0;
			end else if (src_idle_en && $urandom_range(0, 9) == 0) begin
				src_gap <= $urandom_range(0, 13);
				in_valid <= 1'b0;
			end else if (pending_blocks.size() != 0) begin
				in_data <= pending_blocks.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_go)
			hold_left <= LONG_HOLD;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		if (!arst_n || hold_go || hold_left != 0) begin
			out_ready <= 1'b0;
		end else if (snk_gap != 0) begin
			snk_gap <= snk_gap - 1;
			out_ready <= 1'b0;
		end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
			snk_gap <= $urandom_range(0, 13);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		blk_out_t got;
		blk_out_t want;
		if (arst_n) begin
			if (blocks_if.valid && blocks_if.ready)
				expected_smoothed.push_back(smooth_block(blocks_if.data, threshold_now));
			if (smoothed_if.valid && smoothed_if.ready) begin
				got = smoothed_if.data;
				if (expected_smoothed.size() == 0) begin
					report_mismatch("unexpected result", got.out_top_left, 8'h00);
				end else begin
					want = expected_smoothed.pop_front();
					if (got.out_top_left !== want.out_top_left)
						report_mismatch("out_top_left", got.out_top_left, want.out_top_left);
					if (got.out_top_right !== want.out_top_right)
						report_mismatch("out_top_right", got.out_top_right, want.out_top_right);
					if (got.out_bottom_left !== want.out_bottom_left)
						report_mismatch("out_bottom_left", got.out_bottom_left,
							want.out_bottom_left);
					if (got.out_bottom_right !== want.out_bottom_right)
						report_mismatch("out_bottom_right", got.out_bottom_right,
							want.out_bottom_right);
				end
			end
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);

		push_block(" ", " ", " ", " ", 1'b1, 1'b1);
		push_block("@", "@", "@", "@", 1'b1, 1'b1);
		push_block("@", " ", " ", " ", 1'b1, 1'b1);
		push_block(" ", "@", " ", " ", 1'b1, 1'b1);
		push_block(" ", " ", "@", " ", 1'b1, 1'b1);
		push_block(" ", " ", " ", "@", 1'b1, 1'b1);
		push_block(" ", "@", "@", "@", 1'b1, 1'b1);
		push_block("@", "@", "@", " ", 1'b1, 1'b1);
		push_block("@", "@", "@", "@", 1'b0, 1'b1);
		push_block("@", "@", "@", "@", 1'b1, 1'b0);
		push_block("@", "@", "@", "@", 1'b0, 1'b0);
		push_block(" ", "@", "@", "@", 1'b0, 1'b0);
		push_block(".", ":", "-", "=", 1'b1, 1'b1);
		push_block("+", "*", "#", "%", 1'b1, 1'b1);
		push_block(8'h00, 8'hFF, 8'h41, "@", 1'b1, 1'b1);
		push_block(8'hFF, 8'h00, 8'h7F, 8'h80, 1'b1, 1'b1);
		push_block("@", 8'h55, 8'hAA, 8'h01, 1'b1, 1'b1);
		push_block("%", "@", " ", ".", 1'b0, 1'b1);
		push_block("@", "#", ".", " ", 1'b1, 1'b0);
		push_block(8'hFE, "@", 8'h00, "@", 1'b0, 1'b0);
		drain();

		set_threshold(8'd0);
		push_block("@", "@", "@", "@", 1'b1, 1'b1);
		push_block(" ", "@", "@", "@", 1'b1, 1'b1);
		push_block("@", "%", "#", "*", 1'b1, 1'b1);
		run_random(120);

		set_threshold(8'd255);
		push_block("@", " ", " ", " ", 1'b1, 1'b1);
		run_random(60);

		// let the block fill while the receiver holds off
		set_threshold(8'd1);
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		repeat (120)
			pending_blocks.push_back(random_block());
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		drain();
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;

		set_threshold(8'($urandom_range(20, 200)));
		run_random(150);

		set_threshold(8'd64);
		run_random(150);

		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		set_threshold(8'($urandom_range(0, 255)));
		run_random(150);

		repeat (12) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
rtl/absd_pkg.sv
rtl/absd_stream_if.sv
rtl/absd_cell.sv
rtl/ascii_block_smoothing_dither.sv
tb/ascii_block_smoothing_dither_tb.sv
